// ===== rtl/aes128_block_encrypt_assert.svh =====
// Assertion macros for the AES-128 block encrypt checker
`ifndef AES128_BLOCK_ENCRYPT_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_ASSERT_SVH
// Implication checked on every rising clock edge, disabled during reset
`define AES_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define AES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, S-box and GF(2^8) helpers for the AES-128 pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;
	localparam int NumRounds = 10;
	localparam int RegIdxW = 1;
	localparam logic [RegIdxW-1:0] REG_KEY_HIGH = 1'b0;
	localparam logic [RegIdxW-1:0] REG_KEY_LOW  = 1'b1;

	typedef logic [127:0] blk_t;
	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic valid;
		logic stall;
	} stg_ctl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [NumRounds] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	// byte n at bits 127-8n
	function automatic byte_t get_byte(input blk_t b, input int n);
		return b[127-8*n -: 8];
	endfunction

	function automatic byte_t xtime(input byte_t b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic blk_t sub_shift(input blk_t s);
		blk_t t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c+r)%4))];
		return t;
	endfunction

	function automatic blk_t mix(input blk_t s);
		blk_t t;
		byte_t a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c);
			a1 = get_byte(s, 4*c+1);
			a2 = get_byte(s, 4*c+2);
			a3 = get_byte(s, 4*c+3);
			t[127-32*c -: 8]    = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			t[119-32*c -: 8]    = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			t[111-32*c -: 8]    = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			t[103-32*c -: 8]    = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		return t;
	endfunction

	function automatic blk_t next_key(input blk_t k, input byte_t rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction
endpackage
`default_nettype wire

// ===== rtl/aes128_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// aes128_block_encrypt
// AES-128 encryption pipeline, one block per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: plaintext blocks, tdata[63:0] = block_high, [127:64] = block_low.
//   m_axis: ciphertext, same packing (cipher_high low, cipher_low high).
//   cfg: write channel, cfg_index 0 = key_high, 1 = key_low; write only idle.
//   From input transfer to m_axis_tvalid a block passes eleven registers
//   in a row, one for the initial AddRoundKey, loaded at the transfer edge,
//   and one per round cell, ten cells in a row.
//   Throughput one block per cycle unless the output stalls; the key travels with
//   each block down the chain, so every cell does its own schedule step.
//   When m_axis_tready is low the whole chain holds (global enable) once the
//   last stage holds a result, and s_axis_tready drops only then.
//   Reset clears the key to zero and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module aes128_block_encrypt (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [127:0] s_axis_tdata,   // block_high, block_low
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [127:0]      m_axis_tdata,   // cipher_high, cipher_low
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [63:0]  cfg_index,
	input  wire logic [63:0]  cfg_data
);
	import aes_pkg::*;

	logic [63:0] key_high_q, key_low_q;
	blk_t key, blk_in;
	logic en;
	logic v0_q;
	blk_t st0_q, k0_q;
	logic [NumRounds:0] v;
	blk_t st [NumRounds+1];
	blk_t kk [NumRounds+1];

	assign cfg_ready = 1'b1;
	assign key = {key_high_q, key_low_q};
	assign blk_in = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
	assign en = m_axis_tready || !v[NumRounds];
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_valid && cfg_index[63:1] == '0) begin
			unique case (cfg_index[0])
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
		end else if (en) begin
			v0_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st0_q <= blk_in ^ key;
			k0_q  <= key;
		end
	end

	assign v[0]  = v0_q;
	assign st[0] = st0_q;
	assign kk[0] = k0_q;

	for (genvar i = 0; i < NumRounds; i++) begin : g_round
		aes_round_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.last     (i == NumRounds - 1),
			.rcon     (RCON[i]),
			.valid_in (v[i]),
			.state_in (st[i]),
			.key_in   (kk[i]),
			.valid_q  (v[i+1]),
			.state_q  (st[i+1]),
			.key_q    (kk[i+1])
		);
	end

	assign m_axis_tvalid = v[NumRounds];
	assign m_axis_tdata  = {st[NumRounds][63:0], st[NumRounds][127:64]};
endmodule
`default_nettype wire

// ===== rtl/aes_round_cell.sv =====
// ----------------------------------------------------------------------------
// aes_round_cell
// One round of the pipeline: key schedule step and state round, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_round_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          last,
	input  wire logic [7:0]    rcon,
	input  wire logic          valid_in,
	input  wire aes_pkg::blk_t state_in,
	input  wire aes_pkg::blk_t key_in,
	output logic               valid_q,
	output aes_pkg::blk_t      state_q,
	output aes_pkg::blk_t      key_q
);
	import aes_pkg::*;

	blk_t rk, ss, nxt;

	always_comb begin
		rk  = next_key(key_in, rcon);
		ss  = sub_shift(state_in);
		nxt = (last ? ss : mix(ss)) ^ rk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_q <= nxt;
			key_q   <= rk;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/aes_checker.sv =====
// ----------------------------------------------------------------------------
// aes_checker
// Port-level checks on the AES-128 pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aes128_block_encrypt_assert.svh"
module aes_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [127:0] m_axis_tdata,
	input wire logic         cfg_ready
);
	`AES_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
	`AES_ASSERT_IMP(a_ready_free, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")
	`AES_ASSERT_IMP(a_ready_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken into stalled chain")
	`AES_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready, "config port not ready")
endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (.*);
`default_nettype wire
